### design/lcbf_pkg.sv
// Package for the line command byte FIFO.
// Holds item structs, status codes, state type and shared constants.
// No dependencies.
package lcbf_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int CNT_W     = 6;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0a;

	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_CMD   = 2'd2,
		ST_CMD_BYTE = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       data_out;
		status_t          status;
		logic             last;
		logic [CNT_W-1:0] pending_lines;
		logic [CNT_W-1:0] fill_level;
	} rsp_t;

endpackage

### design/line_command_byte_fifo.sv
// Line command byte FIFO, top level. Uses lcbf_pkg and lcbf_mem.
// Push: the result is registered in the cycle after the item is taken.
// Fetch: first byte via the byte store read and result registers. One
// push, or one fetched byte, a cycle while the result side accepts.
// Reset (arst_n low, asynchronous): pointers, counts and state clear;
// byte store contents are left as they are.
module line_command_byte_fifo
	import lcbf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] FULL_LEVEL = CNT_W'(DEPTH - 1);
	localparam logic [AW-1:0]    LAST_SLOT  = AW'(DEPTH - 1);

	state_t           state_q, state_d;
	logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
	logic [AW-1:0]    wr_next, rd_next;
	logic [CNT_W-1:0] fill_q, fill_d, line_q, line_d;
	logic             rsp_valid_q, load, slot_free, end_line, done;
	rsp_t             rsp_q, rsp_d;
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [7:0]       mem_rdata;

	lcbf_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_ptr_q),
		.wdata (cmd.data_in),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign wr_next   = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
	assign rd_next   = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign end_line  = (mem_rdata == NEWLINE_BYTE);
	assign done      = end_line || (fill_q == CNT_W'(1));

	always_comb begin
		state_d   = state_q;
		wr_ptr_d  = wr_ptr_q;
		rd_ptr_d  = rd_ptr_q;
		fill_d    = fill_q;
		line_d    = line_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = rd_ptr_q;
		load      = 1'b0;
		cmd_ready = 1'b0;
		rsp_d     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = slot_free;
				if (cmd_valid && slot_free) begin
					if (cmd.action == ACT_PUSH) begin
						load       = 1'b1;
						rsp_d.last = 1'b1;
						if (fill_q == FULL_LEVEL) begin
							rsp_d.status = ST_FULL;
						end else begin
							rsp_d.status = ST_ACCEPTED;
							mem_we       = 1'b1;
							wr_ptr_d     = wr_next;
							fill_d       = fill_q + CNT_W'(1);
							if (cmd.data_in == NEWLINE_BYTE) begin
								line_d = line_q + CNT_W'(1);
							end
						end
					end else if (line_q == '0 || fill_q == '0) begin
						load         = 1'b1;
						rsp_d.last   = 1'b1;
						rsp_d.status = ST_NO_CMD;
					end else begin
						mem_re  = 1'b1;
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					load     = 1'b1;
					rd_ptr_d = rd_next;
					fill_d   = fill_q - CNT_W'(1);
					if (end_line) begin
						line_d = line_q - CNT_W'(1);
					end else if (fill_q == CNT_W'(1)) begin
						line_d = '0;
					end
					rsp_d.data_out = mem_rdata;
					rsp_d.status   = ST_CMD_BYTE;
					rsp_d.last     = done;
					if (done) begin
						state_d = S_IDLE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = rd_next;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		rsp_d.pending_lines = line_d;
		rsp_d.fill_level    = fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			line_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			fill_q   <= fill_d;
			line_q   <= line_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_no_take_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> !cmd_ready)
		else $error("command taken during line emission");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_LEVEL)
		else $error("fill level beyond capacity");

	a_lines_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= fill_q)
		else $error("more lines counted than bytes stored");

	a_not_last_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.status == ST_CMD_BYTE && state_q == S_EMIT))
		else $error("non-final result outside a fetch");

endmodule

### design/lcbf_mem.sv
// Byte store of the line command byte FIFO.
// One write port, one read port with a registered read that holds when idle.
// No package dependencies.
module lcbf_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the line command byte FIFO: a tracker class predicts
// every result, and tasks drive pushes and fetches with random bursts and stalls.
// Depends on lcbf_pkg and line_command_byte_fifo.
module tb_top;
	import lcbf_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 350;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 20;

	typedef enum int {
		SC_LINE,
		SC_FETCH,
		SC_NOISE,
		SC_FILL,
		SC_LONG_LINE,
		SC_DRAIN
	} scenario_t;

	class line_fifo_tracker;
		logic [7:0] byte_store [DEPTH];
		int         wr_ptr;
		int         rd_ptr;
		int         lines;
		rsp_t       due_rsp [$];
		int         errors;
		int         pushes;
		int         refused;
		int         fetches;
		int         no_line;
		int         lines_popped;
		int         longest_line;
		int         most_lines;

		function new();
			foreach (byte_store[i]) byte_store[i] = '0;
			wr_ptr       = 0;
			rd_ptr       = 0;
			lines        = 0;
			errors       = 0;
			pushes       = 0;
			refused      = 0;
			fetches      = 0;
			no_line      = 0;
			lines_popped = 0;
			longest_line = 0;
			most_lines   = 0;
		endfunction

		function int fill();
			return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + DEPTH - rd_ptr;
		endfunction

		function int next_slot(int p);
			return (p + 1 >= DEPTH) ? 0 : p + 1;
		endfunction

		function void add_due(logic [7:0] d, status_t s, logic l);
			rsp_t r;
			r.data_out      = d;
			r.status        = s;
			r.last          = l;
			r.pending_lines = CNT_W'(lines);
			r.fill_level    = CNT_W'(fill());
			due_rsp.push_back(r);
		endfunction

		function void note_cmd(cmd_t c);
			logic [7:0] ch;
			int         n;
			if (c.action == ACT_PUSH) begin
				pushes++;
				if (fill() + 1 >= DEPTH) begin
					refused++;
					add_due(8'h00, ST_FULL, 1'b1);
				end else begin
					byte_store[wr_ptr] = c.data_in;
					wr_ptr = next_slot(wr_ptr);
					if (c.data_in == NEWLINE_BYTE)
						lines = (lines + 1) % 64;
					if (lines > most_lines)
						most_lines = lines;
					add_due(8'h00, ST_ACCEPTED, 1'b1);
				end
			end else begin
				fetches++;
				if (lines == 0 || fill() == 0) begin
					no_line++;
					add_due(8'h00, ST_NO_CMD, 1'b1);
				end else begin
					n = 0;
					while (fill() > 0 && n < DEPTH - 1) begin
						ch = byte_store[rd_ptr];
						rd_ptr = next_slot(rd_ptr);
						n++;
						if (ch == NEWLINE_BYTE) begin
							lines--;
							add_due(ch, ST_CMD_BYTE, 1'b1);
							break;
						end
						if (fill() == 0) begin
							lines = 0;
							add_due(ch, ST_CMD_BYTE, 1'b1);
							break;
						end
						add_due(ch, ST_CMD_BYTE, 1'b0);
					end
					lines_popped++;
					if (n > longest_line)
						longest_line = n;
				end
			end
		endfunction

		function void check_rsp(rsp_t got);
			rsp_t want;
			if (due_rsp.size() == 0) begin
				errors++;
				$error("unexpected result: data_out %0h status %0d last %0b",
					got.data_out, got.status, got.last);
				return;
			end
			want = due_rsp.pop_front();
			if (got.data_out !== want.data_out) begin
				errors++;
				$error("data_out: expected %0h, got %0h", want.data_out, got.data_out);
			end
			if (got.status !== want.status) begin
				errors++;
				$error("status: expected %0d, got %0d", want.status, got.status);
			end
			if (got.last !== want.last) begin
				errors++;
				$error("last: expected %0b, got %0b", want.last, got.last);
			end
			if (got.pending_lines !== want.pending_lines) begin
				errors++;
				$error("pending_lines: expected %0d, got %0d",
					want.pending_lines, got.pending_lines);
			end
			if (got.fill_level !== want.fill_level) begin
				errors++;
				$error("fill_level: expected %0d, got %0d", want.fill_level, got.fill_level);
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int         burst_left    = 0;
	int         items_sent    = 0;
	int         idle_cycles   = 0;
	int         ready_phase   = 0;
	logic [7:0] ready_pattern = 8'hff;

	line_fifo_tracker sb = new();

	line_command_byte_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (ready_phase == 0) begin
			if ($urandom_range(0, 3) == 0)
				ready_pattern <= 8'hff;
			else
				ready_pattern <= 8'($urandom) | 8'h01;
		end
		rsp_ready   <= ready_pattern[ready_phase % 8];
		ready_phase <= (ready_phase + 1) % 64;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_rsp(rsp);
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic idle_sender(int n);
		repeat (n) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			cmd       <= cmd_t'($urandom);
		end
	endtask

	task automatic send_item(logic act, logic [7:0] data);
		cmd_t c;
		c.action  = act;
		c.data_in = data;
		if (burst_left == 0) begin
			idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		sb.note_cmd(c);
		items_sent++;
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == NEWLINE_BYTE)
			b = ~b;
		return b;
	endfunction

	task automatic run_scenario(scenario_t sc);
		int   len;
		logic all_nl;
		case (sc)
			SC_LINE: begin
				len = $urandom_range(0, 12);
				repeat (len) send_item(ACT_PUSH, body_byte());
				send_item(ACT_PUSH, NEWLINE_BYTE);
				if ($urandom_range(0, 1) == 1)
					send_item(ACT_FETCH, 8'($urandom));
			end
			SC_FETCH: begin
				repeat ($urandom_range(1, 3)) send_item(ACT_FETCH, 8'($urandom));
			end
			SC_NOISE: begin
				repeat ($urandom_range(1, 8))
					send_item(1'($urandom),
						($urandom_range(0, 3) == 0) ? NEWLINE_BYTE : 8'($urandom));
			end
			SC_FILL: begin
				all_nl = ($urandom_range(0, 3) == 0);
				while (sb.fill() < DEPTH - 1)
					send_item(ACT_PUSH, (all_nl || $urandom_range(0, 2) == 0) ?
						NEWLINE_BYTE : body_byte());
				repeat (2) send_item(ACT_PUSH, 8'($urandom));
			end
			SC_LONG_LINE: begin
				while (sb.lines > 0) send_item(ACT_FETCH, 8'($urandom));
				while (sb.fill() < DEPTH - 2) send_item(ACT_PUSH, body_byte());
				send_item(ACT_PUSH, NEWLINE_BYTE);
				send_item(ACT_FETCH, 8'($urandom));
			end
			default: begin
				while (sb.lines > 0) send_item(ACT_FETCH, 8'($urandom));
				send_item(ACT_FETCH, 8'($urandom));
			end
		endcase
	endtask

	initial begin
		int        rand_start;
		int        round;
		int        pick;
		scenario_t sc;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty, then bytes without a newline, then simple lines
		send_item(ACT_FETCH, 8'h00);
		send_item(ACT_PUSH, 8'h00);
		send_item(ACT_FETCH, 8'h00);
		send_item(ACT_PUSH, 8'hff);
		send_item(ACT_PUSH, NEWLINE_BYTE);
		send_item(ACT_FETCH, 8'hff);
		send_item(ACT_FETCH, 8'h00);
		send_item(ACT_PUSH, NEWLINE_BYTE);
		send_item(ACT_PUSH, NEWLINE_BYTE);
		send_item(ACT_PUSH, 8'h55);
		send_item(ACT_PUSH, 8'haa);
		send_item(ACT_PUSH, 8'h0b);
		send_item(ACT_PUSH, 8'h09);
		send_item(ACT_PUSH, NEWLINE_BYTE);
		send_item(ACT_FETCH, 8'h0a);
		send_item(ACT_FETCH, 8'h00);
		send_item(ACT_FETCH, 8'h00);
		send_item(ACT_FETCH, 8'hff);

		rand_start = items_sent;
		round = 0;
		while (items_sent - rand_start < RANDOM_ITEMS) begin
			if (round <= SC_DRAIN) begin
				sc = scenario_t'(round);
			end else begin
				pick = $urandom_range(0, 15);
				if (pick <= 6)
					sc = SC_LINE;
				else if (pick <= 9)
					sc = SC_FETCH;
				else if (pick <= 11)
					sc = SC_NOISE;
				else if (pick == 12)
					sc = SC_FILL;
				else if (pick == 13)
					sc = SC_LONG_LINE;
				else
					sc = SC_DRAIN;
			end
			run_scenario(sc);
			round++;
		end

		idle_sender(1);
		while (sb.due_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items: %0d pushes (%0d refused full), %0d fetches (%0d with no line)",
			items_sent, sb.pushes, sb.refused, sb.fetches, sb.no_line);
		$display("Popped %0d lines, longest %0d bytes; up to %0d lines held at once",
			sb.lines_popped, sb.longest_line, sb.most_lines);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
